// File: hw/rtl/approach_point_at_distance_macros.svh
// assertion macros for the standoff point block
`ifndef APPROACH_POINT_AT_DISTANCE_MACROS_SVH
`define APPROACH_POINT_AT_DISTANCE_MACROS_SVH

// implication checked on every clock edge outside reset
`define APD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define APD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/apd_pkg.sv
package apd_pkg;

    localparam int CoordW = 32;
    localparam int DistW = 31;
    localparam int HeadW = 16;
    localparam int AngW = 28;
    localparam int PW = 48;
    localparam int XW = 36;
    localparam int CordicStepsDef = 16;
    localparam int MaxSteps = 32;

    localparam logic signed [AngW-1:0] PiQ24 = 28'sd52707179;
    localparam logic [29:0] InvGainQ30 = 30'd652032874;
    localparam logic signed [HeadW-1:0] HeadingMax = 16'sd25736;
    localparam logic [DistW-1:0] DistReset = 31'd65536;

    localparam logic [0:0] RegDist = 1'b0;

    typedef struct packed {
        logic signed [CoordW-1:0] goal_x;
        logic signed [CoordW-1:0] goal_y;
        logic signed [CoordW-1:0] robot_x;
        logic signed [CoordW-1:0] robot_y;
        logic                     pose_valid;
    } apd_in_t;

    typedef struct packed {
        logic signed [CoordW-1:0] approach_x;
        logic signed [CoordW-1:0] approach_y;
        logic signed [HeadW-1:0]  heading;
        logic                     ok;
    } apd_out_t;

    // one item in flight through the rotation stages
    typedef struct packed {
        logic signed [XW-1:0]     x;
        logic signed [XW-1:0]     y;
        logic signed [AngW-1:0]   ang;
        logic signed [PW-1:0]     px;
        logic signed [PW-1:0]     py;
        logic                     flip;
        logic                     zero;
        logic                     ok;
        logic signed [CoordW-1:0] gx;
        logic signed [CoordW-1:0] gy;
        logic [DistW-1:0]         standoff;
    } apd_stage_t;

    function automatic logic signed [AngW-1:0] atan_q24(input int i);
        logic signed [AngW-1:0] r;
        case (i)
            0: r = 28'sd13176795;
            1: r = 28'sd7778716;
            2: r = 28'sd4110060;
            3: r = 28'sd2086331;
            4: r = 28'sd1047214;
            5: r = 28'sd524117;
            6: r = 28'sd262123;
            7: r = 28'sd131069;
            default: r = (i < 25) ? AngW'(28'sd65536 >>> (i - 8)) : '0;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/apd_front.sv
module apd_front
    import apd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  apd_in_t          in_data,
    input  logic [DistW-1:0] standoff,
    output logic             out_vld,
    output apd_stage_t       out_data
);

    logic       s1_vld_reg;
    apd_in_t    s1_in_reg;
    logic [DistW-1:0] s1_dist_reg;
    logic [60:0] s1_prod_reg;

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    apd_stage_t st_next;
    apd_stage_t st_reg;
    logic       vld_reg;

    // stage 1: gain multiply and register the inputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_in_reg   <= in_data;
        s1_dist_reg <= standoff;
        s1_prod_reg <= 61'(standoff) * 61'(InvGainQ30);
    end

    // stage 2: differences, half-plane fold
    always_comb
    begin
        dx = XW'(s1_in_reg.goal_x) - XW'(s1_in_reg.robot_x);
        dy = XW'(s1_in_reg.goal_y) - XW'(s1_in_reg.robot_y);
        st_next = '0;
        st_next.ok = s1_in_reg.pose_valid;
        st_next.gx = s1_in_reg.goal_x;
        st_next.gy = s1_in_reg.goal_y;
        st_next.standoff = s1_dist_reg;
        st_next.zero = (dx == '0) && (dy == '0);
        st_next.px = PW'((s1_prod_reg + 61'd32768) >> 16);
        st_next.py = '0;
        if (dx < 0)
        begin
            st_next.flip = 1'b1;
            st_next.ang = (dy >= 0) ? PiQ24 : -PiQ24;
            st_next.x = -dx;
            st_next.y = -dy;
        end
        else
        begin
            st_next.x = dx;
            st_next.y = dy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    assign out_vld  = vld_reg;
    assign out_data = st_reg;

endmodule

// File: hw/rtl/apd_cordic_stage.sv
module apd_cordic_stage
    import apd_pkg::*;
#(
    parameter int Idx = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_vld,
    input  apd_stage_t in_data,
    output logic       out_vld,
    output apd_stage_t out_data
);

    apd_stage_t st_next;
    apd_stage_t st_reg;
    logic       vld_reg;

    always_comb
    begin
        st_next = in_data;
        if (in_data.y >= 0)
        begin
            st_next.x   = in_data.x + (in_data.y >>> Idx);
            st_next.y   = in_data.y - (in_data.x >>> Idx);
            st_next.ang = in_data.ang + atan_q24(Idx);
            st_next.px  = in_data.px - (in_data.py >>> Idx);
            st_next.py  = in_data.py + (in_data.px >>> Idx);
        end
        else
        begin
            st_next.x   = in_data.x - (in_data.y >>> Idx);
            st_next.y   = in_data.y + (in_data.x >>> Idx);
            st_next.ang = in_data.ang - atan_q24(Idx);
            st_next.px  = in_data.px + (in_data.py >>> Idx);
            st_next.py  = in_data.py - (in_data.px >>> Idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    assign out_vld  = vld_reg;
    assign out_data = st_reg;

endmodule

// File: hw/rtl/apd_back.sv
module apd_back
    import apd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_vld,
    input  apd_stage_t in_data,
    output logic       out_vld,
    output apd_out_t   out_data
);

    logic signed [PW-1:0]   px_f;
    logic signed [PW-1:0]   py_f;
    logic signed [CoordW+1:0] cx;
    logic signed [CoordW+1:0] cy;
    logic signed [AngW-1:0] ang;
    logic signed [AngW-1:0] hd;
    logic signed [CoordW+2:0] ax;
    logic signed [CoordW+2:0] ay;
    logic signed [CoordW+1:0] c_x_reg;
    logic signed [CoordW+1:0] c_y_reg;
    logic signed [HeadW-1:0]  hd_reg;
    logic signed [CoordW-1:0] gx_reg;
    logic signed [CoordW-1:0] gy_reg;
    logic ok_reg;
    logic vld1_reg;
    apd_out_t res_next;
    apd_out_t res_reg;
    logic vld_reg;

    function automatic logic signed [CoordW-1:0] sat(input logic signed [CoordW+2:0] v);
        logic signed [CoordW-1:0] r;
        if (v > (CoordW+3)'(33'sh0_7FFF_FFFF))
            r = {1'b0, {(CoordW-1){1'b1}}};
        else if (v < -(CoordW+3)'(33'sh0_8000_0000))
            r = {1'b1, {(CoordW-1){1'b0}}};
        else
            r = v[CoordW-1:0];
        return r;
    endfunction

    // stage a: unfold, round to q16.16, heading
    always_comb
    begin
        px_f = in_data.flip ? -in_data.px : in_data.px;
        py_f = in_data.flip ? -in_data.py : in_data.py;
        if (in_data.zero)
        begin
            cx  = (CoordW+2)'(in_data.standoff);
            cy  = '0;
            ang = '0;
        end
        else
        begin
            cx  = (CoordW+2)'((px_f + PW'(8192)) >>> 14);
            cy  = (CoordW+2)'((py_f + PW'(8192)) >>> 14);
            ang = in_data.ang;
        end
        hd = (ang + AngW'(1024)) >>> 11;
        if (hd > AngW'(HeadingMax))
            hd = AngW'(HeadingMax);
        if (hd < -AngW'(HeadingMax))
            hd = -AngW'(HeadingMax);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld_reg  <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_vld;
            vld_reg  <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_x_reg <= cx;
        c_y_reg <= cy;
        hd_reg  <= hd[HeadW-1:0];
        gx_reg  <= in_data.gx;
        gy_reg  <= in_data.gy;
        ok_reg  <= in_data.ok;
    end

    // stage b: subtract from goal and saturate
    always_comb
    begin
        ax = (CoordW+3)'(gx_reg) - (CoordW+3)'(c_x_reg);
        ay = (CoordW+3)'(gy_reg) - (CoordW+3)'(c_y_reg);
        res_next = '0;
        if (ok_reg)
        begin
            res_next.approach_x = sat(ax);
            res_next.approach_y = sat(ay);
            res_next.heading    = hd_reg;
            res_next.ok         = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_vld  = vld_reg;
    assign out_data = res_reg;

endmodule

// File: hw/rtl/approach_point_at_distance.sv
// standoff point toward a goal, with heading
//
// input channel: start/busy command port carrying an apd_in_t; busy is tied
// low, so an item is taken on every clock edge where start is high
// result channel: done pulses for one cycle with the apd_out_t in result;
// the receiver has no way to stall, none is needed
// configuration: apb write to address 0 sets approach_distance (q16.16)
//
// pipeline: two front stages for the gain multiply and the half-plane
// fold, one stage per micro-rotation, two back stages for rounding and
// saturation
// throughput: one item per cycle; the pipeline stage count sets the latency
//
// reset: clears all valid bits and loads the distance with 1.0 m; payload
// registers are not cleared
// an invalid pose still gives a result, with every field zero
module approach_point_at_distance
    import apd_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDef
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  apd_in_t     operand,
    output logic        done,
    output apd_out_t    result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // at most 32 micro-rotations are meaningful
    localparam int Steps = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;

    logic [DistW-1:0] dist_reg;

    // register write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= DistReset;
        end
        else if (psel && penable && pwrite && (paddr[1:1] == RegDist))
        begin
            dist_reg <= pwdata[DistW-1:0];
        end
    end

    assign prdata = (paddr[1:1] == RegDist) ? {1'b0, dist_reg} : '0;
    assign pready = 1'b1;
    assign busy   = 1'b0;

    logic       vld [Steps+1];
    apd_stage_t st  [Steps+1];

    apd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (start),
        .in_data  (operand),
        .standoff (dist_reg),
        .out_vld  (vld[0]),
        .out_data (st[0])
    );

    // one pipeline stage per micro-rotation
    for (genvar i = 0; i < Steps; i++)
    begin : g_rot
        apd_cordic_stage #(.Idx(i)) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (vld[i]),
            .in_data  (st[i]),
            .out_vld  (vld[i+1]),
            .out_data (st[i+1])
        );
    end

    apd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (vld[Steps]),
        .in_data  (st[Steps]),
        .out_vld  (done),
        .out_data (result)
    );

endmodule

// File: hw/rtl/apd_checker.sv
`include "approach_point_at_distance_macros.svh"
module apd_checker
    import apd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     busy,
    input logic     done,
    input apd_out_t result,
    input logic     pready
);

    `APD_ASSERT_IMP(a_never_busy, clk, rst_n, 1'b1, !busy && pready)
    `APD_ASSERT_IMP(a_ok_zero, clk, rst_n, done && !result.ok, result.approach_x == 0 && result.heading == 0)
    `APD_ASSERT_IMP(a_head_rng, clk, rst_n, done, result.heading <= HeadingMax && result.heading >= -HeadingMax)

endmodule

bind approach_point_at_distance apd_checker u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (busy),
    .done   (done),
    .result (result),
    .pready (pready)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import apd_pkg::*;

    localparam int STEPS = CordicStepsDef;
    localparam int LATENCY = STEPS + 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] DIST_ADDR = 2'(4 * int'(RegDist));
    localparam int RANDOM_PHASES = 5;
    localparam int ITEMS_PER_PHASE = 400;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    apd_in_t     operand;
    logic        done;
    apd_out_t    result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // one directed row: a typed expectation where it is obvious, else predicted
    typedef struct {
        apd_in_t  op;
        bit       typed;
        apd_out_t want;
    } directed_row_t;

    apd_out_t        pending_points[$];
    directed_row_t   directed_rows[$];
    logic [DistW-1:0] standoff_dist;
    longint          arctan_q24[32];
    int              error_count;
    int              transfers_sent;
    int              transfers_checked;
    int              cycle_count;

    approach_point_at_distance #(
        .CORDIC_STEPS(STEPS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operand (operand),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // arctangent table in units of 2^-24 rad, rounded to nearest
    initial
    begin
        arctan_q24[0] = 13176795;
        arctan_q24[1] = 7778716;
        arctan_q24[2] = 4110060;
        arctan_q24[3] = 2086331;
        arctan_q24[4] = 1047214;
        arctan_q24[5] = 524117;
        arctan_q24[6] = 262123;
        arctan_q24[7] = 131069;
        for (int i = 8; i < 32; i++)
            arctan_q24[i] = (i < 25) ? (longint'(65536) >>> (i - 8)) : 0;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // standoff point and heading for one pose, at the current distance
    function automatic apd_out_t predict_standoff(apd_in_t op, logic [DistW-1:0] standoff);
        apd_out_t          r;
        longint            gx, gy, x, y, px, py, ang, cx, cy, hd, xs, ys, pxs, pys;
        longint unsigned   pk;
        bit                flip;
        r = '0;
        if (!op.pose_valid)
            return r;
        gx = longint'(op.goal_x);
        gy = longint'(op.goal_y);
        x = gx - longint'(op.robot_x);
        y = gy - longint'(op.robot_y);
        ang = 0;
        if (x == 0 && y == 0)
        begin
            // coinciding positions: back off along x only
            cx = longint'(standoff);
            cy = 0;
        end
        else
        begin
            pk = (longint'(standoff) * longint'(InvGainQ30) + 32768) >> 16;
            px = longint'(pk);
            py = 0;
            flip = 1'b0;
            // left half-plane: turn by pi first
            if (x < 0)
            begin
                flip = 1'b1;
                ang = (y >= 0) ? longint'(PiQ24) : -longint'(PiQ24);
                x = -x;
                y = -y;
            end
            for (int i = 0; i < ((STEPS > 32) ? 32 : STEPS); i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                pxs = px >>> i;
                pys = py >>> i;
                if (y >= 0)
                begin
                    x += ys;
                    y -= xs;
                    ang += arctan_q24[i];
                    px -= pys;
                    py += pxs;
                end
                else
                begin
                    x -= ys;
                    y += xs;
                    ang -= arctan_q24[i];
                    px += pys;
                    py -= pxs;
                end
            end
            if (flip)
            begin
                px = -px;
                py = -py;
            end
            cx = (px + 8192) >>> 14;
            cy = (py + 8192) >>> 14;
        end
        hd = (ang + 1024) >>> 11;
        if (hd > longint'(HeadingMax))
            hd = longint'(HeadingMax);
        if (hd < -longint'(HeadingMax))
            hd = -longint'(HeadingMax);
        r.approach_x = 32'(clamp32(gx - cx));
        r.approach_y = 32'(clamp32(gy - cy));
        r.heading = 16'(hd);
        r.ok = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d (transfer %0d)",
                 what, got, want, transfers_checked);
        error_count++;
    endtask

    // result side: every done pulse is compared with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_points.size() == 0)
                report_mismatch("unexpected transfer", 1, 0);
            else
            begin
                apd_out_t want;
                want = pending_points.pop_front();
                if (result.approach_x !== want.approach_x)
                    report_mismatch("approach_x", result.approach_x, want.approach_x);
                if (result.approach_y !== want.approach_y)
                    report_mismatch("approach_y", result.approach_y, want.approach_y);
                if (result.heading !== want.heading)
                    report_mismatch("heading", result.heading, want.heading);
                if (result.ok !== want.ok)
                    report_mismatch("ok", result.ok, want.ok);
                transfers_checked++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // apb write with setup and access cycles, then a read back
    task automatic write_standoff(logic [DistW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= DIST_ADDR;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        standoff_dist = value;
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[DistW-1:0] !== value)
            report_mismatch("approach_distance read back", prdata[DistW-1:0], value);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // one command transfer; start stays high through a burst
    task automatic send_pose(apd_in_t op, apd_out_t want, int gap);
        operand <= op;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_points.push_back(want);
        transfers_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // waits out the pipeline before a register write
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic apd_in_t make_pose(int gx, int gy, int rx, int ry, bit valid);
        apd_in_t op;
        op.goal_x = gx;
        op.goal_y = gy;
        op.robot_x = rx;
        op.robot_y = ry;
        op.pose_valid = valid;
        return op;
    endfunction

    task automatic add_row(apd_in_t op, bit typed, apd_out_t want);
        directed_row_t row;
        row.op = op;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    function automatic apd_out_t known_point(int ax, int ay, int hd, bit ok);
        apd_out_t r;
        r.approach_x = ax;
        r.approach_y = ay;
        r.heading = 16'(hd);
        r.ok = ok;
        return r;
    endfunction

    // random pose, mostly well-formed with a mix of scales and corners
    function automatic apd_in_t random_pose();
        apd_in_t op;
        int      kind;
        kind = $urandom_range(0, 9);
        op.goal_x = $urandom;
        op.goal_y = $urandom;
        op.robot_x = $urandom;
        op.robot_y = $urandom;
        op.pose_valid = ($urandom_range(0, 9) != 0);
        case (kind)
            0, 1, 2:
            begin
                // nearby points, a few meters apart
                op.robot_x = op.goal_x + $signed(32'($urandom_range(0, 1 << 20)) - (1 << 19));
                op.robot_y = op.goal_y + $signed(32'($urandom_range(0, 1 << 20)) - (1 << 19));
            end
            3:
            begin
                op.robot_x = op.goal_x;
                op.robot_y = op.goal_y;
            end
            4:
            begin
                // on an axis
                if ($urandom_range(0, 1))
                    op.robot_x = op.goal_x;
                else
                    op.robot_y = op.goal_y;
            end
            5:
            begin
                op.goal_x = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
                op.robot_y = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            end
            default:
            begin
            end
        endcase
        return op;
    endfunction

    initial
    begin
        apd_out_t         want;
        int               gap;
        int               burst_left;
        logic [DistW-1:0] phase_dist[RANDOM_PHASES];

        rst_n = 1'b0;
        start = 1'b0;
        operand = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        transfers_sent = 0;
        transfers_checked = 0;
        cycle_count = 0;
        standoff_dist = DistReset;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset distance of 1.0 m
        add_row(make_pose(32'h7fffffff, 32'h80000000, 5, -5, 1'b0), 1, known_point(0, 0, 0, 0));
        add_row(make_pose(-1, -1, -1, -1, 1'b0), 1, known_point(0, 0, 0, 0));
        add_row(make_pose(0, 0, 0, 0, 1'b1), 1, known_point(-65536, 0, 0, 1));
        add_row(make_pose(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1),
                1, known_point(32'h80000000, 32'h7fffffff, 0, 1));
        add_row(make_pose(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1),
                1, known_point(32'h7ffeffff, 32'h80000000, 0, 1));
        add_row(make_pose(3 << 16, 0, 0, 0, 1'b1), 0, '0);
        add_row(make_pose(-(3 << 16), 0, 0, 0, 1'b1), 0, '0);
        add_row(make_pose(0, 3 << 16, 0, 0, 1'b1), 0, '0);
        add_row(make_pose(0, -(3 << 16), 0, 0, 1'b1), 0, '0);
        add_row(make_pose(-(2 << 16), 1 << 16, 0, 0, 1'b1), 0, '0);
        add_row(make_pose(-(2 << 16), -(1 << 16), 0, 0, 1'b1), 0, '0);
        add_row(make_pose(1, 1, 0, 0, 1'b1), 0, '0);
        add_row(make_pose(-1, 0, 0, 0, 1'b1), 0, '0);
        add_row(make_pose(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 1'b1), 0, '0);
        add_row(make_pose(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b1), 0, '0);
        add_row(make_pose(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b1), 0, '0);
        add_row(make_pose(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 1'b1), 0, '0);
        add_row(make_pose(32'h80000000, 0, 32'h80000000 + 1, 0, 1'b1), 0, '0);
        foreach (directed_rows[i])
        begin
            want = directed_rows[i].typed ? directed_rows[i].want
                                          : predict_standoff(directed_rows[i].op, standoff_dist);
            send_pose(directed_rows[i].op, want, $urandom_range(0, 2));
        end

        // random phases, each at its own standoff distance
        phase_dist[0] = '0;
        phase_dist[1] = '1;
        phase_dist[2] = DistW'($urandom_range(0, 32'h7fffffff));
        phase_dist[3] = DistW'($urandom_range(0, 5 << 16));
        phase_dist[4] = DistReset;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_pipeline();
            write_standoff(phase_dist[p]);
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                apd_in_t op;
                op = random_pose();
                // bursts of back-to-back transfers, with random gaps between them
                if (burst_left > 0)
                begin
                    burst_left--;
                    gap = 0;
                end
                else
                begin
                    burst_left = $urandom_range(0, 20);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                send_pose(op, predict_standoff(op, standoff_dist), gap);
            end
        end

        // let the pipeline empty out
        start <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        $display("%0d poses sent, %0d results checked, %0d standoff distances incl. 0 and max",
                 transfers_sent, transfers_checked, RANDOM_PHASES + 1);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
